// ===== rtl/vvsl_pkg.sv =====
package vvsl_pkg;

   // Fixed field widths of the stream payload and the step register.
   localparam int TURN_WIDTH = 16;
   localparam int STEP_WIDTH = 7;

   localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(3);

   typedef logic [TURN_WIDTH-1:0] turn_type;
   typedef logic [STEP_WIDTH-1:0] step_type;

endpackage

// ===== rtl/vvsl_alu.sv =====
module vvsl_alu #(
   parameter int MUL_WIDTH = 16,
   parameter int SUB_WIDTH = 20
) (
   input  logic                     clock,
   input  logic [MUL_WIDTH-1:0]     mul_a,
   input  logic [MUL_WIDTH-1:0]     mul_b,
   output logic [2*MUL_WIDTH-1:0]   mul_p,
   input  logic [SUB_WIDTH-1:0]     sub_a,
   input  logic [SUB_WIDTH-1:0]     sub_b,
   output logic [SUB_WIDTH-1:0]     sub_d,
   output logic                     sub_ge
);

   logic [2*MUL_WIDTH-1:0] mul_p_ff;
   logic [SUB_WIDTH:0]     sub_full;

   // Product is registered; it shows up in the cycle after the operands.
   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   assign mul_p = mul_p_ff;

   // Trial subtract: borrow out clear means a >= b.
   assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_d    = sub_full[SUB_WIDTH-1:0];
   assign sub_ge   = ~sub_full[SUB_WIDTH];

endmodule

// ===== rtl/velocity_vector_slew_limiter.sv =====
// Sequence: the first beat after reset goes straight to ST_DONE and rsp_tvalid; a change
//   within the step snaps after the compare; a limited change runs the square root and both divides.
// Throughput: one beat at a time; req_tready is high only in the idle state, so the next
//   beat can be taken in the cycle after the result is loaded. The shared multiplier and the
//   bit-serial compare-subtract (square root, then two restoring divides) set the time per beat.
// Reset (synchronous, active high): velocity zero, not started, max_step = 3, no result.
module velocity_vector_slew_limiter
   import vvsl_pkg::*;
#(
   parameter int VEL_WIDTH = 16,
   parameter int FRAC_BITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: target_vx, target_vy, turn_rate (lowest first), zero padded to bytes
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [((2*VEL_WIDTH+TURN_WIDTH+7)/8)*8-1:0] req_tdata,
   // rsp_tdata: out_vx, out_vy, out_turn (lowest first), zero padded to bytes
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [((2*VEL_WIDTH+TURN_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // max_step write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [STEP_WIDTH-1:0] csr_data
);

   localparam int VW    = VEL_WIDTH;
   localparam int LW    = STEP_WIDTH + FRAC_BITS;       // step limit in Q units
   localparam int MW    = (VW > LW) ? VW : LW;          // multiplier operand width
   localparam int PW    = VW + LW;                      // |d| * L, also the quotient width
   localparam int SW    = 2 * VW + 2;                   // |d|^2, padded to whole bit pairs
   localparam int CW    = (SW > 2 * LW) ? SW : 2 * LW;  // width of the snap compare
   localparam int QW    = VW + 1;                       // square root
   localparam int RW    = VW + 4;                       // compare-subtract width
   localparam int DW    = 2 * VW + TURN_WIDTH;
   localparam int TW    = ((DW + 7) / 8) * 8;
   localparam int CNT_W = $clog2(PW + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIFF  = 4'd1;
   localparam logic [3:0] ST_SQX   = 4'd2;
   localparam logic [3:0] ST_SQY   = 4'd3;
   localparam logic [3:0] ST_LSQ   = 4'd4;
   localparam logic [3:0] ST_CMP   = 4'd5;
   localparam logic [3:0] ST_SQRT  = 4'd6;
   localparam logic [3:0] ST_MUL   = 4'd7;
   localparam logic [3:0] ST_DLOAD = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_APPLY = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   // Control state
   logic [3:0]       state_ff, state_in;
   logic             started_ff, started_in;
   step_type         max_step_ff, max_step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             axis_ff, axis_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Datapath
   logic [VW-1:0]    cur_x_ff, cur_x_in;
   logic [VW-1:0]    cur_y_ff, cur_y_in;
   logic [VW-1:0]    tx_ff, tx_in;
   logic [VW-1:0]    ty_ff, ty_in;
   turn_type         turn_ff, turn_in;
   logic [VW-1:0]    ax_ff, ax_in;
   logic [VW-1:0]    ay_ff, ay_in;
   logic             nx_ff, nx_in;
   logic             ny_ff, ny_in;
   logic [SW-1:0]    sum_ff, sum_in;
   logic [VW+1:0]    rem_ff, rem_in;
   logic [QW-1:0]    root_ff, root_in;
   logic [PW-1:0]    dvd_ff, dvd_in;
   logic [TW-1:0]    rsp_data_ff, rsp_data_in;

   // Shared unit
   logic [MW-1:0]    mul_a, mul_b;
   logic [2*MW-1:0]  mul_p;
   logic [RW-1:0]    sub_a, sub_b, sub_d;
   logic             sub_ge;

   logic             req_fire;
   logic [LW-1:0]    lim;
   logic [VW:0]      dx, dy;
   logic [VW-1:0]    quot, step;

   vvsl_alu #(
      .MUL_WIDTH (MW),
      .SUB_WIDTH (RW)
   ) u_alu (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .mul_p  (mul_p),
      .sub_a  (sub_a),
      .sub_b  (sub_b),
      .sub_d  (sub_d),
      .sub_ge (sub_ge)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Step limit L = max_step scaled into Q units
   assign lim = LW'(max_step_ff) << FRAC_BITS;

   // Change vector, one bit wider than a velocity
   assign dx = {tx_ff[VW-1], tx_ff} - {cur_x_ff[VW-1], cur_x_ff};
   assign dy = {ty_ff[VW-1], ty_ff} - {cur_y_ff[VW-1], cur_y_ff};

   // Quotient never exceeds |d|, so its low bits carry the whole step
   assign quot = dvd_ff[VW-1:0];
   assign step = (axis_ff ? ny_ff : nx_ff) ? (VW'(0) - quot) : quot;

   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      max_step_in  = max_step_ff;
      rsp_valid_in = rsp_valid_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      turn_in      = turn_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      dvd_in       = dvd_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      sub_a        = '0;
      sub_b        = '0;

      if (csr_valid) begin
         max_step_in = csr_data;
      end

      // Drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               tx_in   = req_tdata[VW-1:0];
               ty_in   = req_tdata[2*VW-1:VW];
               turn_in = req_tdata[2*VW+TURN_WIDTH-1:2*VW];
               if (!started_ff) begin
                  // First beat loads the target outright
                  cur_x_in   = req_tdata[VW-1:0];
                  cur_y_in   = req_tdata[2*VW-1:VW];
                  started_in = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            nx_in    = dx[VW];
            ny_in    = dy[VW];
            ax_in    = dx[VW] ? VW'(-dx) : dx[VW-1:0];
            ay_in    = dy[VW] ? VW'(-dy) : dy[VW-1:0];
            state_in = ST_SQX;
         end
         ST_SQX: begin
            mul_a    = MW'(ax_ff);
            mul_b    = MW'(ax_ff);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sum_in   = SW'(mul_p[2*VW-1:0]);
            mul_a    = MW'(ay_ff);
            mul_b    = MW'(ay_ff);
            state_in = ST_LSQ;
         end
         ST_LSQ: begin
            sum_in   = sum_ff + SW'(mul_p[2*VW-1:0]);
            mul_a    = MW'(lim);
            mul_b    = MW'(lim);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (CW'(sum_ff) <= CW'(mul_p[2*LW-1:0])) begin
               // Within one step: snap to the target
               cur_x_in = tx_ff;
               cur_y_in = ty_ff;
               state_in = ST_DONE;
            end else begin
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CNT_W'(VW);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // One root bit per cycle, bit pairs taken from the top of sum_ff
            sub_a  = {rem_ff, sum_ff[SW-1:SW-2]};
            sub_b  = RW'({root_ff, 2'b01});
            sum_in = sum_ff << 2;
            if (sub_ge) begin
               rem_in  = sub_d[VW+1:0];
               root_in = {root_ff[QW-2:0], 1'b1};
            end else begin
               rem_in  = sub_a[VW+1:0];
               root_in = {root_ff[QW-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               axis_in  = 1'b0;
               state_in = ST_MUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MUL: begin
            mul_a    = MW'(axis_ff ? ay_ff : ax_ff);
            mul_b    = MW'(lim);
            state_in = ST_DLOAD;
         end
         ST_DLOAD: begin
            dvd_in   = mul_p[PW-1:0];
            rem_in   = '0;
            cnt_in   = CNT_W'(PW - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring divide by the root; quotient bits shift in behind the dividend
            sub_a = RW'({rem_ff[VW:0], dvd_ff[PW-1]});
            sub_b = RW'(root_ff);
            if (sub_ge) begin
               rem_in = sub_d[VW+1:0];
            end else begin
               rem_in = sub_a[VW+1:0];
            end
            dvd_in = {dvd_ff[PW-2:0], sub_ge};
            if (cnt_ff == '0) begin
               state_in = ST_APPLY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_APPLY: begin
            if (axis_ff) begin
               cur_y_in = cur_y_ff + step;
               state_in = ST_DONE;
            end else begin
               cur_x_in = cur_x_ff + step;
               axis_in  = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = TW'({turn_ff, cur_y_ff, cur_x_ff});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         max_step_ff  <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         max_step_ff  <= max_step_in;
         rsp_valid_ff <= rsp_valid_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      turn_ff     <= turn_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      dvd_ff      <= dvd_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/vvsl_checker.sv =====
module vvsl_checker
   import vvsl_pkg::*;
#(
   parameter int VEL_WIDTH = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [((2*VEL_WIDTH+TURN_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic                  csr_valid,
   input logic                  csr_ready
);

   logic [1:0] pending_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Beats accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_fire && !rsp_fire) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("req_tready high right after an accepted beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed or dropped");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 2'd0))
      else $error("response without an accepted request");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two beats in flight");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind velocity_vector_slew_limiter vvsl_checker #(
   .VEL_WIDTH (VEL_WIDTH)
) u_vvsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
